// ----- rtl/rolling_hash_pattern_search_assert.svh -----
// Assertion macros for the rolling hash pattern search block.
// Used by the top level; needs a clock and reset in scope.
`ifndef ROLLING_HASH_PATTERN_SEARCH_ASSERT_SVH
`define ROLLING_HASH_PATTERN_SEARCH_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define RHPS_ASSERT_IMPL(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) else $error(msg);

// Next-cycle implication checked outside reset.
`define RHPS_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) else $error(msg);

`endif

// ----- rtl/rhps_pkg.sv -----
// Shared types and constants for the rolling hash pattern search block.
// No dependencies.
package rhps_pkg;

   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 5;
   localparam int IDX_W   = 4;
   localparam int POS_W   = 32;
   localparam int REG_W   = 64;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LEN  = 2'd2;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

endpackage

// ----- rtl/rhps_cell.sv -----
// One window cell: holds one text byte, hands it to the next cell on shift,
// and compares its incoming byte with its pattern byte. Uses rhps_pkg.
module rhps_cell (
   input  logic                        clock,
   input  rhps_pkg::cell_ctl_type      ctl,
   input  logic [rhps_pkg::BYTE_W-1:0] byte_in,
   input  logic [rhps_pkg::BYTE_W-1:0] pat_byte,
   input  logic                        active,
   output logic [rhps_pkg::BYTE_W-1:0] byte_out,
   output logic                        hit
);

   logic [rhps_pkg::BYTE_W-1:0] byte_ff;
   logic [rhps_pkg::BYTE_W-1:0] byte_load_in;

   always_comb begin
      byte_load_in = ctl.clear ? '0 : byte_in;
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         byte_ff <= byte_load_in;
      end
   end

   assign byte_out = byte_ff;
   assign hit      = !active || (byte_load_in == pat_byte);

endmodule

// ----- rtl/rolling_hash_pattern_search.sv -----
// Top level of the rolling hash pattern search block.
// Uses rhps_pkg, rhps_cell and rolling_hash_pattern_search_assert.svh.
//
// Text enters one byte per word on the req_ channel; req_text_start marks the
// first byte of a new text and clears the window, fill count and position.
// Every accepted word gives one rsp_ word: rsp_match_found is set when the
// last pattern_length bytes equal the pattern, and rsp_match_position is the
// zero-based index of the first byte of that window (0 when no match).
// rsp_valid rises in the cycle after acceptance. Throughput is one word per
// cycle while the receiver does not stall: a chain of PATTERN_MAX byte cells
// shifts and compares in parallel, and the result goes to an output register.
// When the receiver stalls, the held result stays and req_stall rises for as
// long as the output register is full and stalled. The user must write the
// pattern registers through csr_ only while idle; the block does not enforce
// it. Reset clears pattern, fill count and position and sets the length to one.
`include "rolling_hash_pattern_search_assert.svh"

module rolling_hash_pattern_search #(
   parameter int PATTERN_MAX = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [rhps_pkg::BYTE_W-1:0]     req_text_byte,
   input  logic                            req_text_start,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_match_found,
   output logic [rhps_pkg::POS_W-1:0]      rsp_match_position,
   input  logic                            csr_wr_en,
   input  logic [rhps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rhps_pkg::REG_W-1:0]      csr_write_data
);

   localparam logic [rhps_pkg::LEN_W-1:0] LEN_MAX = rhps_pkg::LEN_W'(PATTERN_MAX);
   localparam logic [rhps_pkg::POS_W-1:0] POS_SAT = '1;

   logic [rhps_pkg::REG_W-1:0]  pat_low_ff;
   logic [rhps_pkg::REG_W-1:0]  pat_high_ff;
   logic [rhps_pkg::LEN_W-1:0]  pat_len_ff;
   logic [rhps_pkg::LEN_W-1:0]  fill_ff;
   logic [rhps_pkg::LEN_W-1:0]  fill_in;
   logic [rhps_pkg::POS_W-1:0]  count_ff;
   logic [rhps_pkg::POS_W-1:0]  count_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic                        match_ff;
   logic                        match_in;
   logic [rhps_pkg::POS_W-1:0]  pos_ff;
   logic [rhps_pkg::POS_W-1:0]  pos_in;

   logic                        accept;
   logic [rhps_pkg::LEN_W-1:0]  eff_len;
   logic [rhps_pkg::LEN_W-1:0]  fill_base;
   logic [rhps_pkg::LEN_W-1:0]  fill_next;
   logic [rhps_pkg::POS_W-1:0]  idx;
   logic [2*rhps_pkg::REG_W-1:0] pat_all;
   logic [PATTERN_MAX-1:0]      hits;

   logic [rhps_pkg::BYTE_W-1:0] cell_q [PATTERN_MAX];

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign pat_all   = {pat_high_ff, pat_low_ff};

   always_comb begin
      priority if (pat_len_ff == '0) begin
         eff_len = rhps_pkg::LEN_W'(1);
      end else if (pat_len_ff > LEN_MAX) begin
         eff_len = LEN_MAX;
      end else begin
         eff_len = pat_len_ff;
      end
   end

   // Window chain: cell 0 takes the new byte, cell k takes cell k-1.
   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      rhps_pkg::cell_ctl_type      ctl;
      logic [rhps_pkg::BYTE_W-1:0] byte_in;
      logic [rhps_pkg::LEN_W-1:0]  pat_pos;
      logic [rhps_pkg::BYTE_W-1:0] pat_byte;
      logic                        active;

      assign active   = rhps_pkg::LEN_W'(k) < eff_len;
      assign pat_pos  = eff_len - rhps_pkg::LEN_W'(1) - rhps_pkg::LEN_W'(k);
      assign pat_byte = pat_all[pat_pos[rhps_pkg::IDX_W-1:0]*rhps_pkg::BYTE_W +:
                                rhps_pkg::BYTE_W];
      assign ctl.shift = accept;

      if (k == 0) begin : g_head
         assign byte_in   = req_text_byte;
         assign ctl.clear = 1'b0;
      end else begin : g_body
         assign byte_in   = cell_q[k-1];
         assign ctl.clear = req_text_start;
      end

      rhps_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .byte_in  (byte_in),
         .pat_byte (pat_byte),
         .active   (active),
         .byte_out (cell_q[k]),
         .hit      (hits[k])
      );
   end

   always_comb begin
      fill_base = req_text_start ? '0 : fill_ff;
      idx       = req_text_start ? '0 : count_ff;
      fill_next = (fill_base < LEN_MAX) ? fill_base + rhps_pkg::LEN_W'(1) : fill_base;
      count_in  = (idx == POS_SAT) ? idx : idx + rhps_pkg::POS_W'(1);
      fill_in   = fill_next;
      match_in  = (fill_next >= eff_len) && (&hits);
      pos_in    = match_in ?
                  idx - rhps_pkg::POS_W'(eff_len - rhps_pkg::LEN_W'(1)) : '0;
      rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff   <= '0;
         pat_high_ff  <= '0;
         pat_len_ff   <= rhps_pkg::LEN_W'(1);
         fill_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               rhps_pkg::CSR_PATTERN_LOW:  pat_low_ff  <= csr_write_data;
               rhps_pkg::CSR_PATTERN_HIGH: pat_high_ff <= csr_write_data;
               rhps_pkg::CSR_PATTERN_LEN:  pat_len_ff  <= csr_write_data[rhps_pkg::LEN_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            fill_ff  <= fill_in;
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         match_ff <= match_in;
         pos_ff   <= pos_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_match_found    = match_ff;
   assign rsp_match_position = pos_ff;

   `RHPS_ASSERT_IMPL(a_pos_zero_on_miss, rsp_valid_ff && !match_ff, pos_ff == '0, "position set without match")
   `RHPS_ASSERT_NEXT(a_start_no_match, accept && req_text_start && eff_len != rhps_pkg::LEN_W'(1), !match_ff, "match on first byte of long pattern")
   `RHPS_ASSERT_NEXT(a_accept_gives_rsp, accept, rsp_valid_ff, "accepted word gave no result")
   `RHPS_ASSERT_IMPL(a_fill_bound, 1'b1, fill_ff <= LEN_MAX, "fill count beyond window")

endmodule

// ----- bench/tb_rolling_hash_pattern_search.sv -----
// Self-checking testbench for rolling_hash_pattern_search: a directed plan, then random
// texts with planted pattern copies under many pattern settings, with random idling.
// Depends on rhps_pkg and the block's RTL only.
module tb_rolling_hash_pattern_search;

   typedef enum logic {ROW_WORD, ROW_CFG} row_kind_type;

   typedef struct packed {
      row_kind_type                     kind;
      logic                             start;
      logic [rhps_pkg::BYTE_W-1:0]      text;
      logic [rhps_pkg::CSR_IDX_W-1:0]   reg_sel;
      logic [rhps_pkg::REG_W-1:0]       value;
      logic                             typed;
      logic                             found;
      logic [rhps_pkg::POS_W-1:0]       pos;
   } plan_row_type;

   typedef struct {
      logic                        found;
      logic [rhps_pkg::POS_W-1:0]  position;
   } match_type;

   localparam int PLAN_ROWS = 28;
   localparam int PHASES = 10;
   localparam int PHASE_WORDS = 53;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [rhps_pkg::BYTE_W-1:0]     req_text_byte = '0;
   logic                            req_text_start = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic                            rsp_match_found;
   logic [rhps_pkg::POS_W-1:0]      rsp_match_position;
   logic                            csr_wr_en = 1'b0;
   logic [rhps_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [rhps_pkg::REG_W-1:0]      csr_write_data = '0;

   // predictor state
   logic [rhps_pkg::REG_W-1:0]      pat_lo = '0;
   logic [rhps_pkg::REG_W-1:0]      pat_hi = '0;
   logic [rhps_pkg::LEN_W-1:0]      pat_len = 5'd1;
   logic [rhps_pkg::BYTE_W-1:0]     window_bytes [16];
   int unsigned                     window_count = 0;
   logic [rhps_pkg::POS_W-1:0]      next_index = '0;

   match_type             pending_matches [$];
   int                    mismatches = 0;
   bit                    idle_on = 1'b1;

   plan_row_type plan [PLAN_ROWS] = '{
      '{ROW_WORD, 1'b1, 8'h00, rhps_pkg::CSR_PATTERN_LOW, 64'd0, 1'b1, 1'b1, 32'd0},
      '{ROW_WORD, 1'b0, 8'hFF, rhps_pkg::CSR_PATTERN_LOW, 64'd0, 1'b1, 1'b0, 32'd0},
      '{ROW_WORD, 1'b0, 8'h65, rhps_pkg::CSR_PATTERN_LOW, 64'd0, 1'b1, 1'b0, 32'd0},
      '{ROW_WORD, 1'b0, 8'h00, rhps_pkg::CSR_PATTERN_LOW, 64'd0, 1'b1, 1'b1, 32'd3},
      '{ROW_CFG,  1'b0, 8'h00, rhps_pkg::CSR_PATTERN_LEN, 64'd0, 1'b0, 1'b0, 32'd0},
      '{ROW_WORD, 1'b0, 8'h00, rhps_pkg::CSR_PATTERN_LOW, 64'd0, 1'b1, 1'b1, 32'd4},
      '{ROW_CFG,  1'b0, 8'h00, rhps_pkg::CSR_PATTERN_LOW,
        64'h8877665544332211, 1'b0, 1'b0, 32'd0},
      '{ROW_CFG,  1'b0, 8'h00, rhps_pkg::CSR_PATTERN_HIGH,
        64'hFF00EEDDCCBBAA99, 1'b0, 1'b0, 32'd0},
      '{ROW_CFG,  1'b0, 8'h00, rhps_pkg::CSR_PATTERN_LEN, 64'd31, 1'b0, 1'b0, 32'd0},
      '{ROW_WORD, 1'b1, 8'h11, rhps_pkg::CSR_PATTERN_LOW, 64'd0, 1'b1, 1'b0, 32'd0},
      '{ROW_WORD, 1'b0, 8'h22, rhps_pkg::CSR_PATTERN_LOW, 64'd0, 1'b1, 1'b0, 32'd0},
      '{ROW_WORD, 1'b0, 8'h33, rhps_pkg::CSR_PATTERN_LOW, 64'd0, 1'b1, 1'b0, 32'd0},
      '{ROW_WORD, 1'b0, 8'h44, rhps_pkg::CSR_PATTERN_LOW, 64'd0, 1'b1, 1'b0, 32'd0},
      '{ROW_WORD, 1'b0, 8'h55, rhps_pkg::CSR_PATTERN_LOW, 64'd0, 1'b1, 1'b0, 32'd0},
      '{ROW_WORD, 1'b0, 8'h66, rhps_pkg::CSR_PATTERN_LOW, 64'd0, 1'b1, 1'b0, 32'd0},
      '{ROW_WORD, 1'b0, 8'h77, rhps_pkg::CSR_PATTERN_LOW, 64'd0, 1'b1, 1'b0, 32'd0},
      '{ROW_WORD, 1'b0, 8'h88, rhps_pkg::CSR_PATTERN_LOW, 64'd0, 1'b1, 1'b0, 32'd0},
      '{ROW_WORD, 1'b0, 8'h99, rhps_pkg::CSR_PATTERN_LOW, 64'd0, 1'b1, 1'b0, 32'd0},
      '{ROW_WORD, 1'b0, 8'hAA, rhps_pkg::CSR_PATTERN_LOW, 64'd0, 1'b1, 1'b0, 32'd0},
      '{ROW_WORD, 1'b0, 8'hBB, rhps_pkg::CSR_PATTERN_LOW, 64'd0, 1'b1, 1'b0, 32'd0},
      '{ROW_WORD, 1'b0, 8'hCC, rhps_pkg::CSR_PATTERN_LOW, 64'd0, 1'b1, 1'b0, 32'd0},
      '{ROW_WORD, 1'b0, 8'hDD, rhps_pkg::CSR_PATTERN_LOW, 64'd0, 1'b1, 1'b0, 32'd0},
      '{ROW_WORD, 1'b0, 8'hEE, rhps_pkg::CSR_PATTERN_LOW, 64'd0, 1'b1, 1'b0, 32'd0},
      '{ROW_WORD, 1'b0, 8'h00, rhps_pkg::CSR_PATTERN_LOW, 64'd0, 1'b1, 1'b0, 32'd0},
      '{ROW_WORD, 1'b0, 8'hFF, rhps_pkg::CSR_PATTERN_LOW, 64'd0, 1'b1, 1'b1, 32'd0},
      '{ROW_CFG,  1'b0, 8'h00, rhps_pkg::CSR_PATTERN_LEN, 64'd1, 1'b0, 1'b0, 32'd0},
      '{ROW_WORD, 1'b0, 8'h11, rhps_pkg::CSR_PATTERN_LOW, 64'd0, 1'b0, 1'b0, 32'd0},
      '{ROW_WORD, 1'b0, 8'h12, rhps_pkg::CSR_PATTERN_LOW, 64'd0, 1'b0, 1'b0, 32'd0}
   };

   int len_pick [PHASES] = '{0, 1, 2, 3, 4, 8, 15, 16, 17, 31};

   rolling_hash_pattern_search dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_text_byte      (req_text_byte),
      .req_text_start     (req_text_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_match_found    (rsp_match_found),
      .rsp_match_position (rsp_match_position),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int active_length();
      int n;
      n = int'(pat_len);
      if (n == 0) n = 1;
      if (n > 16) n = 16;
      return n;
   endfunction

   function automatic logic [rhps_pkg::BYTE_W-1:0] pattern_byte(int j);
      logic [2*rhps_pkg::REG_W-1:0] p;
      p = {pat_hi, pat_lo};
      return p[8*j +: 8];
   endfunction

   function automatic logic [rhps_pkg::BYTE_W-1:0] pick_byte(int mode);
      case (mode)
         0: return rhps_pkg::BYTE_W'($urandom_range(0, 255));
         1: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         default: return rhps_pkg::BYTE_W'(8'h41 + $urandom_range(0, 2));
      endcase
   endfunction

   task automatic predict_match(input logic [rhps_pkg::BYTE_W-1:0] b, input logic s,
                                output match_type m);
      logic [rhps_pkg::POS_W-1:0] idx;
      int n;
      if (s) begin
         foreach (window_bytes[k]) window_bytes[k] = '0;
         window_count = 0;
         next_index = '0;
      end
      idx = next_index;
      if (next_index != '1) next_index = next_index + 1;
      for (int k = 15; k > 0; k--) window_bytes[k] = window_bytes[k-1];
      window_bytes[0] = b;
      if (window_count < 16) window_count++;
      n = active_length();
      m.found = (window_count >= n);
      for (int j = 0; j < n; j++)
         if (window_bytes[n-1-j] != pattern_byte(j)) m.found = 1'b0;
      m.position = m.found ? idx - rhps_pkg::POS_W'(n - 1) : '0;
   endtask

   task automatic report_mismatch(input string what, input logic [rhps_pkg::POS_W-1:0] got,
                                  input logic [rhps_pkg::POS_W-1:0] want);
      $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // one text word, with its sender gap; typed values override the predictor
   task automatic send_word(input logic [rhps_pkg::BYTE_W-1:0] b, input logic s,
                            input logic typed, input logic f_typed,
                            input logic [rhps_pkg::POS_W-1:0] p_typed);
      int gap;
      match_type m;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= b;
      req_text_start <= s;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_match(b, s, m);
      if (typed) begin
         m.found = f_typed;
         m.position = p_typed;
      end
      pending_matches = {pending_matches, m};
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_matches.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // caller lowers csr_wr_en after the last write
   task automatic program_reg(input logic [rhps_pkg::CSR_IDX_W-1:0] sel,
                              input logic [rhps_pkg::REG_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_write_data <= data;
      case (sel)
         rhps_pkg::CSR_PATTERN_LOW:  pat_lo = data;
         rhps_pkg::CSR_PATTERN_HIGH: pat_hi = data;
         rhps_pkg::CSR_PATTERN_LEN:  pat_len = data[rhps_pkg::LEN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // receiver: check each accepted result, then draw the next stall
   initial begin
      int unsigned hold;
      match_type m;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
            if (pending_matches.size() == 0) begin
               report_mismatch("unexpected word", rsp_match_position, '0);
            end else begin
               m = pending_matches.pop_front();
               if (rsp_match_found !== m.found)
                  report_mismatch("match_found", rhps_pkg::POS_W'(rsp_match_found),
                                  rhps_pkg::POS_W'(m.found));
               if (rsp_match_position !== m.position)
                  report_mismatch("match_position", rsp_match_position, m.position);
            end
            hold = idle_on ? $urandom_range(0, 3) : 0;
         end
         @(negedge clock);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic [rhps_pkg::REG_W-1:0] lo, hi;
      logic [rhps_pkg::BYTE_W-1:0] b;
      int mode, sent, n, bad_at;
      foreach (window_bytes[k]) window_bytes[k] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[r]) begin
         if (plan[r].kind == ROW_CFG) begin
            settle();
            program_reg(plan[r].reg_sel, plan[r].value);
            csr_wr_en <= 1'b0;
         end else begin
            send_word(plan[r].text, plan[r].start, plan[r].typed, plan[r].found, plan[r].pos);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         settle();
         mode = $urandom_range(0, 2);
         idle_on = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
         for (int j = 0; j < 8; j++) begin
            lo[8*j +: 8] = pick_byte(mode);
            hi[8*j +: 8] = pick_byte(mode);
         end
         if (p == 1) begin
            lo = '1;
            hi = '1;
         end else if (p == 2) begin
            lo = '0;
            hi = '0;
         end
         program_reg(rhps_pkg::CSR_PATTERN_LOW, lo);
         program_reg(rhps_pkg::CSR_PATTERN_HIGH, hi);
         program_reg(rhps_pkg::CSR_PATTERN_LEN, rhps_pkg::REG_W'(len_pick[p]));
         csr_wr_en <= 1'b0;
         n = active_length();
         sent = 0;
         while (sent < PHASE_WORDS) begin
            if (p == 5 && sent >= PHASE_WORDS / 2 && sent < PHASE_WORDS / 2 + n) settle();
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  // planted copy, sometimes with one byte spoiled
                  bad_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
                  for (int j = 0; j < n; j++) begin
                     b = (j == bad_at) ? pick_byte(mode) : pattern_byte(j);
                     send_word(b, (j == 0) && ($urandom_range(0, 7) == 0), 1'b0, 1'b0, '0);
                     sent++;
                  end
               end
               6, 7, 8: begin
                  repeat ($urandom_range(1, 4)) begin
                     b = ($urandom_range(0, 7) == 0) ? pick_byte(0) : pick_byte(mode);
                     send_word(b, 1'b0, 1'b0, 1'b0, '0);
                     sent++;
                  end
               end
               default: begin
                  send_word(pick_byte(0), 1'b1, 1'b0, 1'b0, '0);
                  sent++;
               end
            endcase
         end
      end

      settle();
      repeat (3) @(negedge clock);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
